// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CCML_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CCML_ASSERT_ALL(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ccml_pkg.sv
// Shared constants, types and helpers of the color cross marker locator.
package ccml_pkg;
	localparam int ARM_LENGTH = 5;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int DIM_W = 11;
	localparam int PIX_W = 8;
	localparam int RING_LINES = 2 * ARM_LENGTH + 1;
	localparam int LINE_W = $clog2(RING_LINES);
	localparam int FLAG_W = 4;
	localparam int FLAG_AW = LINE_W + COL_W;
	localparam int FLAG_DEPTH = 1 << FLAG_AW;
	localparam int BLUE_W = ROW_W + 1;

	localparam int F_PRED = 0;
	localparam int F_R255 = 1;
	localparam int F_PBLUE = 2;
	localparam int F_B255 = 3;

	localparam logic [PIX_W-1:0] PIX_MAX = '1;
	localparam logic [DIM_W-1:0] RST_WIDTH = DIM_W'(640);
	localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);
	localparam logic [PIX_W-1:0] RST_LEVEL = PIX_W'(160);
	localparam logic [PIX_W-1:0] RST_MARGIN = PIX_W'(50);

	typedef enum logic [1:0] {
		CFG_WIDTH = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_LEVEL = 2'd2,
		CFG_MARGIN = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [FLAG_W-1:0] flags;
	} cls_pix_t;

	function automatic logic [LINE_W-1:0] line_add(input logic [LINE_W-1:0] line, input int k);
		logic [LINE_W:0] sum;
		sum = {1'b0, line} + (LINE_W+1)'(k);
		if (sum >= (LINE_W+1)'(RING_LINES))
			sum = sum - (LINE_W+1)'(RING_LINES);
		return sum[LINE_W-1:0];
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		if (v == '0)
			return DIM_W'(1);
		if (v > DIM_W'(hi))
			return DIM_W'(hi);
		return v;
	endfunction
endpackage

// File: rtl/ccml_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ccml_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/ccml_classify.sv
// Pixel classifier: pure red, pure blue or unchanged, plus window flags.
module ccml_classify (
	input logic [ccml_pkg::PIX_W-1:0] pix_red,
	input logic [ccml_pkg::PIX_W-1:0] pix_green,
	input logic [ccml_pkg::PIX_W-1:0] pix_blue,
	input logic [ccml_pkg::PIX_W-1:0] level,
	input logic [ccml_pkg::PIX_W-1:0] margin,
	output ccml_pkg::cls_pix_t cls
);
	import ccml_pkg::*;

	logic [PIX_W:0] g_m, b_m, r_m;
	logic red_hit, blue_hit;

	assign g_m = {1'b0, pix_green} + {1'b0, margin};
	assign b_m = {1'b0, pix_blue} + {1'b0, margin};
	assign r_m = {1'b0, pix_red} + {1'b0, margin};

	assign red_hit = (pix_red > level) && ({1'b0, pix_red} > g_m) && ({1'b0, pix_red} > b_m);
	assign blue_hit = (pix_blue > level) && ({1'b0, pix_blue} > g_m) && ({1'b0, pix_blue} > r_m);

	always_comb begin
		if (red_hit) begin
			cls.red = PIX_MAX;
			cls.green = '0;
			cls.blue = '0;
		end else if (blue_hit) begin
			cls.red = '0;
			cls.green = '0;
			cls.blue = PIX_MAX;
		end else begin
			cls.red = pix_red;
			cls.green = pix_green;
			cls.blue = pix_blue;
		end
		cls.flags[F_PRED] = (cls.red == PIX_MAX) && (cls.green == '0) && (cls.blue == '0);
		cls.flags[F_R255] = (cls.red == PIX_MAX);
		cls.flags[F_PBLUE] = (cls.red == '0) && (cls.green == '0) && (cls.blue == PIX_MAX);
		cls.flags[F_B255] = (cls.blue == PIX_MAX);
	end
endmodule

// File: rtl/color_cross_marker_locator_core.sv
// A pixel with a full window passes states S_R0 to S_R4 before S_DONE; others go to S_DONE directly.
// A frame's last pixel adds a walk over all 1024 columns of the blue store.
// Windowed pixels take four reads of the single flag RAM port; no new pixel is taken until done.
// After reset all 1024 columns of the blue store are cleared; no pixel is taken meanwhile.
// Reset clears counters and marker state and loads the config registers with their reset values.
// Flag RAM contents are undefined until written.
`include "assert_macros.svh"

module color_cross_marker_locator_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [ccml_pkg::DIM_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [ccml_pkg::PIX_W-1:0] pix_red,
	input logic [ccml_pkg::PIX_W-1:0] pix_green,
	input logic [ccml_pkg::PIX_W-1:0] pix_blue,
	output logic out_valid,
	input logic out_stall,
	output logic [ccml_pkg::PIX_W-1:0] out_red,
	output logic [ccml_pkg::PIX_W-1:0] out_green,
	output logic [ccml_pkg::PIX_W-1:0] out_blue,
	output logic frame_done,
	output logic red_found,
	output logic [ccml_pkg::ROW_W-1:0] red_row,
	output logic [ccml_pkg::COL_W-1:0] red_col,
	output logic blue_found,
	output logic [ccml_pkg::ROW_W-1:0] blue_row,
	output logic [ccml_pkg::COL_W-1:0] blue_col
);
	import ccml_pkg::*;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_R0 = 10'b0000000100,
		S_R1 = 10'b0000001000,
		S_R2 = 10'b0000010000,
		S_R3 = 10'b0000100000,
		S_R4 = 10'b0001000000,
		S_WALK = 10'b0010000000,
		S_WEND = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	localparam logic [COL_W-1:0] ARM_C = COL_W'(ARM_LENGTH);
	localparam logic [COL_W:0] WALK_LAST = (COL_W+1)'(MAX_WIDTH - 1);

	state_t state_q;
	logic [DIM_W-1:0] width_q, height_q, w_clamp, h_clamp;
	logic [PIX_W-1:0] level_q, margin_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [LINE_W-1:0] line_q, line_up, line_mid;
	logic [ROW_W-1:0] best_red_row_q, brow_q;
	logic [COL_W-1:0] best_red_col_q, bcol_q;
	logic red_seen_q, bfound_q;
	cls_pix_t cls, cls_q;
	logic fend_q, rend_q;
	logic [FLAG_W-1:0] fa_q, fb_q, fc_q;
	logic [COL_W:0] wcnt_q;
	logic wpend_q;
	logic [COL_W-1:0] wcol_q;
	logic in_acc, out_load;
	logic win_ok, fend_ok, rend_ok;
	logic [ROW_W-1:0] x_row;
	logic red_x, blue_x;

	logic flag_we;
	logic [FLAG_AW-1:0] flag_waddr, flag_raddr;
	logic [FLAG_W-1:0] flag_rd;
	logic blue_we;
	logic [COL_W-1:0] blue_waddr;
	logic [BLUE_W-1:0] blue_wdata, blue_rd;

	ccml_classify u_classify (
		.pix_red(pix_red),
		.pix_green(pix_green),
		.pix_blue(pix_blue),
		.level(level_q),
		.margin(margin_q),
		.cls(cls)
	);

	ccml_ram #(.WIDTH(FLAG_W), .DEPTH(FLAG_DEPTH)) u_flag_ram (
		.clk(clk),
		.we(flag_we),
		.waddr(flag_waddr),
		.wdata(cls.flags),
		.raddr(flag_raddr),
		.rdata(flag_rd)
	);

	ccml_ram #(.WIDTH(BLUE_W), .DEPTH(MAX_WIDTH)) u_blue_ram (
		.clk(clk),
		.we(blue_we),
		.waddr(blue_waddr),
		.wdata(blue_wdata),
		.raddr(wcnt_q[COL_W-1:0]),
		.rdata(blue_rd)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid || !out_stall);

	assign w_clamp = clamp_dim(width_q, MAX_WIDTH);
	assign h_clamp = clamp_dim(height_q, MAX_HEIGHT);
	assign win_ok = (row_q >= ROW_W'(2 * ARM_LENGTH + 1)) && (col_q > ARM_C)
		&& (({1'b0, col_q} + {1'b0, ARM_C}) < w_clamp);
	assign rend_ok = (({1'b0, col_q} + DIM_W'(1)) >= w_clamp);
	assign fend_ok = rend_ok && (({1'b0, row_q} + DIM_W'(1)) >= h_clamp);

	assign line_up = line_add(line_q, RING_LINES - 2 * ARM_LENGTH);
	assign line_mid = line_add(line_q, RING_LINES - ARM_LENGTH);
	assign x_row = row_q - ROW_W'(ARM_LENGTH);

	assign flag_we = in_acc;
	assign flag_waddr = {line_q, col_q};

	always_comb begin
		case (state_q)
			S_R0: flag_raddr = {line_up, col_q};
			S_R1: flag_raddr = {line_mid, col_q};
			S_R2: flag_raddr = {line_mid, col_q - ARM_C};
			default: flag_raddr = {line_mid, col_q + ARM_C};
		endcase
	end

	assign red_x = fb_q[F_PRED] && cls_q.flags[F_R255] && fa_q[F_R255]
		&& fc_q[F_R255] && flag_rd[F_R255];
	assign blue_x = fb_q[F_PBLUE] && cls_q.flags[F_B255] && fa_q[F_B255]
		&& fc_q[F_B255] && flag_rd[F_B255];

	always_comb begin
		blue_we = 1'b0;
		blue_waddr = wcnt_q[COL_W-1:0];
		blue_wdata = '0;
		case (state_q)
			S_CLEAR, S_WALK: blue_we = 1'b1;
			S_R4: begin
				blue_we = blue_x;
				blue_waddr = col_q;
				blue_wdata = {1'b1, x_row};
			end
			default: blue_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cls_q <= cls;
			fend_q <= fend_ok;
			rend_q <= rend_ok;
		end
		case (state_q)
			S_R1: fa_q <= flag_rd;
			S_R2: fb_q <= flag_rd;
			S_R3: fc_q <= flag_rd;
			default: fa_q <= fa_q;
		endcase
		wcol_q <= wcnt_q[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			level_q <= RST_LEVEL;
			margin_q <= RST_MARGIN;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH: width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_LEVEL: level_q <= cfg_data[PIX_W-1:0];
				CFG_MARGIN: margin_q <= cfg_data[PIX_W-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			row_q <= '0;
			col_q <= '0;
			line_q <= '0;
			best_red_row_q <= '0;
			best_red_col_q <= '0;
			red_seen_q <= 1'b0;
			bfound_q <= 1'b0;
			brow_q <= '0;
			bcol_q <= '0;
			wcnt_q <= '0;
			wpend_q <= 1'b0;
		end else begin
			wpend_q <= (state_q == S_WALK);
			if (wpend_q && red_seen_q && (wcol_q < best_red_col_q) && blue_rd[ROW_W]
				&& (!bfound_q || (blue_rd[ROW_W-1:0] >= brow_q))) begin
				bfound_q <= 1'b1;
				brow_q <= blue_rd[ROW_W-1:0];
				bcol_q <= wcol_q;
			end
			case (state_q)
				S_CLEAR, S_WALK: begin
					if (wcnt_q == WALK_LAST) begin
						wcnt_q <= '0;
						state_q <= (state_q == S_CLEAR) ? S_IDLE : S_WEND;
					end else begin
						wcnt_q <= wcnt_q + (COL_W+1)'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						bfound_q <= 1'b0;
						brow_q <= '0;
						bcol_q <= '0;
						if (win_ok)
							state_q <= S_R0;
						else if (fend_ok)
							state_q <= S_WALK;
						else
							state_q <= S_DONE;
					end
				end
				S_R0: state_q <= S_R1;
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_R4;
				S_R4: begin
					if (red_x && (col_q > best_red_col_q)) begin
						best_red_row_q <= x_row;
						best_red_col_q <= col_q;
						red_seen_q <= 1'b1;
					end
					state_q <= fend_q ? S_WALK : S_DONE;
				end
				S_WEND: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
						if (fend_q) begin
							row_q <= '0;
							col_q <= '0;
							line_q <= '0;
							best_red_row_q <= '0;
							best_red_col_q <= '0;
							red_seen_q <= 1'b0;
						end else if (rend_q) begin
							row_q <= row_q + ROW_W'(1);
							col_q <= '0;
							line_q <= line_add(line_q, 1);
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_red <= cls_q.red;
			out_green <= cls_q.green;
			out_blue <= cls_q.blue;
			frame_done <= fend_q;
			red_found <= fend_q && red_seen_q;
			red_row <= (fend_q && red_seen_q) ? best_red_row_q : '0;
			red_col <= (fend_q && red_seen_q) ? best_red_col_q : '0;
			blue_found <= fend_q && bfound_q;
			blue_row <= fend_q ? brow_q : '0;
			blue_col <= fend_q ? bcol_q : '0;
		end
	end

	`CCML_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state_q == S_DONE), "result without completed item")
	`CCML_ASSERT(a_walk_flow, (state_q == S_WALK) |=> (state_q == S_WALK || state_q == S_WEND), "column walk broken")
	`CCML_ASSERT(a_red_idle, !red_seen_q |-> (best_red_col_q == '0 && best_red_row_q == '0), "red marker without flag")
	`CCML_ASSERT_ALL(a_rst_out, !arst_n |-> !out_valid, "result valid during reset")
endmodule
